// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
		else $error("assertion failed");

// antecedent implies consequent, same edge
`define CHK_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/bce_pkg.sv
package bce_pkg;

	localparam int COORD_BITS     = 16;
	localparam int NUM_CTRL       = 5;
	localparam int CNT_BITS       = 3;
	localparam int STEP_BITS      = 16;
	localparam int INDEX_BITS     = 16;
	localparam int T_BITS         = STEP_BITS + INDEX_BITS;
	localparam int MAX_POINTS_DEF = 5;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [CNT_BITS-1:0]  POINT_COUNT_RST = 3'd5;
	localparam logic [STEP_BITS-1:0] T_STEP_RST      = 16'd491;

	typedef enum logic {
		REG_POINT_COUNT = 1'b0,
		REG_T_STEP      = 1'b1
	} reg_idx_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t                  ctrl_x0;
		coord_t                  ctrl_y0;
		coord_t                  ctrl_x1;
		coord_t                  ctrl_y1;
		coord_t                  ctrl_x2;
		coord_t                  ctrl_y2;
		coord_t                  ctrl_x3;
		coord_t                  ctrl_y3;
		coord_t                  ctrl_x4;
		coord_t                  ctrl_y4;
		logic [INDEX_BITS-1:0]   sample_index;
	} item_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   in_range;
	} result_t;

	// control that travels alongside each pipeline stage
	typedef struct packed {
		logic                valid;
		logic                in_range;
		logic [CNT_BITS-1:0] cnt;
	} stage_ctl_t;

	function automatic coord_t ctrl_x(item_t it, int k);
		case (k)
			0:       return it.ctrl_x0;
			1:       return it.ctrl_x1;
			2:       return it.ctrl_x2;
			3:       return it.ctrl_x3;
			4:       return it.ctrl_x4;
			default: return '0;
		endcase
	endfunction

	function automatic coord_t ctrl_y(item_t it, int k);
		case (k)
			0:       return it.ctrl_y0;
			1:       return it.ctrl_y1;
			2:       return it.ctrl_y2;
			3:       return it.ctrl_y3;
			4:       return it.ctrl_y4;
			default: return '0;
		endcase
	endfunction

endpackage

// File: rtl/core/bce_tparam.sv
module bce_tparam #(
	parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = bce_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  bce_pkg::item_t                  item,
	input  logic [bce_pkg::CNT_BITS-1:0]    point_count,
	input  logic [bce_pkg::STEP_BITS-1:0]   t_step,
	output bce_pkg::stage_ctl_t             ctl,
	output logic [FRAC_BITS:0]              tf,
	output bce_pkg::coord_t                 px [MAX_POINTS],
	output bce_pkg::coord_t                 py [MAX_POINTS]
);

	localparam int CAP = (MAX_POINTS < bce_pkg::NUM_CTRL) ? MAX_POINTS : bce_pkg::NUM_CTRL;
	localparam logic [bce_pkg::CNT_BITS-1:0] CAP_CNT = bce_pkg::CNT_BITS'(CAP);

	logic                          valid_s1;
	logic [bce_pkg::CNT_BITS-1:0]  cnt_s1;
	logic [bce_pkg::T_BITS-1:0]    t_s1;
	bce_pkg::coord_t               px_s1 [MAX_POINTS];
	bce_pkg::coord_t               py_s1 [MAX_POINTS];

	logic                          valid_s2;
	logic                          in_range_s2;
	logic [bce_pkg::CNT_BITS-1:0]  cnt_s2;
	logic [FRAC_BITS:0]            tf_s2;
	bce_pkg::coord_t               px_s2 [MAX_POINTS];
	bce_pkg::coord_t               py_s2 [MAX_POINTS];

	logic [bce_pkg::CNT_BITS-1:0]  cnt_sat;
	logic                          in_rng;

	assign cnt_sat = (point_count > CAP_CNT) ? CAP_CNT : point_count;
	// t below one when nothing sits above the fraction bits
	assign in_rng  = (t_s1 >> FRAC_BITS) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_sat;
		t_s1   <= bce_pkg::T_BITS'(item.sample_index) * bce_pkg::T_BITS'(t_step);
		for (int k = 0; k < MAX_POINTS; k++) begin
			px_s1[k] <= bce_pkg::ctrl_x(item, k);
			py_s1[k] <= bce_pkg::ctrl_y(item, k);
		end

		in_range_s2 <= in_rng;
		cnt_s2      <= cnt_s1;
		// clamp t to exactly one once it runs past the end
		tf_s2 <= in_rng ? {1'b0, t_s1[FRAC_BITS-1:0]} : {1'b1, {FRAC_BITS{1'b0}}};
		px_s2 <= px_s1;
		py_s2 <= py_s1;
	end

	assign ctl = '{valid: valid_s2, in_range: in_range_s2, cnt: cnt_s2};
	assign tf  = tf_s2;
	assign px  = px_s2;
	assign py  = py_s2;

endmodule

// File: rtl/core/bce_level.sv
module bce_level #(
	parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = bce_pkg::FRAC_BITS_DEF,
	parameter int LVL        = bce_pkg::MAX_POINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bce_pkg::stage_ctl_t  ctl_in,
	input  logic [FRAC_BITS:0]   tf_in,
	input  bce_pkg::coord_t      px_in  [MAX_POINTS],
	input  bce_pkg::coord_t      py_in  [MAX_POINTS],
	output bce_pkg::stage_ctl_t  ctl_out,
	output logic [FRAC_BITS:0]   tf_out,
	output bce_pkg::coord_t      px_out [MAX_POINTS],
	output bce_pkg::coord_t      py_out [MAX_POINTS]
);

	localparam int C  = bce_pkg::COORD_BITS;
	localparam int SW = C + FRAC_BITS + 3;
	localparam int NL = MAX_POINTS - 1;

	function automatic bce_pkg::coord_t trunc0(logic signed [SW-1:0] s);
		logic signed [SW-1:0] q;
		q = s >>> FRAC_BITS;
		// arithmetic shift floors, so nudge negative values with a remainder up
		if (s[SW-1] && (s[FRAC_BITS-1:0] != '0))
			q = q + SW'(1);
		return q[C-1:0];
	endfunction

	logic signed [C:0]           dx [NL];
	logic signed [C:0]           dy [NL];
	logic signed [FRAC_BITS+1:0] tfs;
	logic signed [SW-1:0]        pdx [NL];
	logic signed [SW-1:0]        pdy [NL];

	logic                        valid_s1;
	logic                        in_range_s1;
	logic [bce_pkg::CNT_BITS-1:0] cnt_s1;
	logic                        act_s1;
	logic [FRAC_BITS:0]          tf_s1;
	bce_pkg::coord_t             px_s1 [MAX_POINTS];
	bce_pkg::coord_t             py_s1 [MAX_POINTS];
	logic signed [SW-1:0]        pdx_s1 [NL];
	logic signed [SW-1:0]        pdy_s1 [NL];

	logic                        valid_s2;
	logic                        in_range_s2;
	logic [bce_pkg::CNT_BITS-1:0] cnt_s2;
	logic [FRAC_BITS:0]          tf_s2;
	bce_pkg::coord_t             px_s2 [MAX_POINTS];
	bce_pkg::coord_t             py_s2 [MAX_POINTS];

	logic signed [SW-1:0]        sx [NL];
	logic signed [SW-1:0]        sy [NL];
	bce_pkg::coord_t             nx [MAX_POINTS];
	bce_pkg::coord_t             ny [MAX_POINTS];

	assign tfs = $signed({1'b0, tf_in});

	always_comb begin
		for (int j = 0; j < NL; j++) begin
			dx[j]  = $signed({px_in[j+1][C-1], px_in[j+1]}) - $signed({px_in[j][C-1], px_in[j]});
			dy[j]  = $signed({py_in[j+1][C-1], py_in[j+1]}) - $signed({py_in[j][C-1], py_in[j]});
			pdx[j] = dx[j] * tfs;
			pdy[j] = dy[j] * tfs;
		end
	end

	always_comb begin
		nx = px_s1;
		ny = py_s1;
		for (int j = 0; j < NL; j++) begin
			sx[j] = (SW'(px_s1[j]) <<< FRAC_BITS) + pdx_s1[j];
			sy[j] = (SW'(py_s1[j]) <<< FRAC_BITS) + pdy_s1[j];
			// levels above the point count pass the points through
			if (act_s1 && (j < LVL - 1)) begin
				nx[j] = trunc0(sx[j]);
				ny[j] = trunc0(sy[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_range_s1 <= ctl_in.in_range;
		cnt_s1      <= ctl_in.cnt;
		act_s1      <= {1'b0, ctl_in.cnt} >= (bce_pkg::CNT_BITS + 1)'(LVL);
		tf_s1       <= tf_in;
		px_s1       <= px_in;
		py_s1       <= py_in;
		pdx_s1      <= pdx;
		pdy_s1      <= pdy;

		in_range_s2 <= in_range_s1;
		cnt_s2      <= cnt_s1;
		tf_s2       <= tf_s1;
		px_s2       <= nx;
		py_s2       <= ny;
	end

	assign ctl_out = '{valid: valid_s2, in_range: in_range_s2, cnt: cnt_s2};
	assign tf_out  = tf_s2;
	assign px_out  = px_s2;
	assign py_out  = py_s2;

endmodule

// File: rtl/core/bezier_curve_point_eval_top.sv
// a taken start strobes its result on done once through the tparam and every level stage pair
// throughput: one transaction per cycle, busy stays low and nothing ever stalls
// depth comes from the t multiply, the clamp, and a multiply then sum stage per curve level
// reset clears every pipeline valid bit at once, so done is low until new work drains out
// reset also sets point_count to 5 and t_step to 491
module bezier_curve_point_eval_top #(
	parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = bce_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bce_pkg::item_t     item,
	output logic               done,
	output bce_pkg::result_t   result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int LAST = MAX_POINTS - 1;

	logic [bce_pkg::CNT_BITS-1:0]  point_count_q;
	logic [bce_pkg::STEP_BITS-1:0] t_step_q;
	bce_pkg::reg_idx_t             reg_sel;

	bce_pkg::stage_ctl_t           ctl_lv [MAX_POINTS];
	logic [FRAC_BITS:0]            tf_lv  [MAX_POINTS];
	bce_pkg::coord_t               px_lv  [MAX_POINTS][MAX_POINTS];
	bce_pkg::coord_t               py_lv  [MAX_POINTS][MAX_POINTS];

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_sel = bce_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= bce_pkg::POINT_COUNT_RST;
			t_step_q      <= bce_pkg::T_STEP_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				bce_pkg::REG_POINT_COUNT: point_count_q <= pwdata[bce_pkg::CNT_BITS-1:0];
				bce_pkg::REG_T_STEP:      t_step_q      <= pwdata[bce_pkg::STEP_BITS-1:0];
				default:                  ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			bce_pkg::REG_POINT_COUNT: prdata = 32'(point_count_q);
			bce_pkg::REG_T_STEP:      prdata = 32'(t_step_q);
			default:                  prdata = '0;
		endcase
	end

	bce_tparam #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_tparam (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (start && !busy),
		.item        (item),
		.point_count (point_count_q),
		.t_step      (t_step_q),
		.ctl         (ctl_lv[0]),
		.tf          (tf_lv[0]),
		.px          (px_lv[0]),
		.py          (py_lv[0])
	);

	// one reduction level per stage pair, highest point count first
	for (genvar g = 0; g < LAST; g++) begin : g_level
		bce_level #(
			.MAX_POINTS (MAX_POINTS),
			.FRAC_BITS  (FRAC_BITS),
			.LVL        (MAX_POINTS - g)
		) u_level (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_lv[g]),
			.tf_in   (tf_lv[g]),
			.px_in   (px_lv[g]),
			.py_in   (py_lv[g]),
			.ctl_out (ctl_lv[g+1]),
			.tf_out  (tf_lv[g+1]),
			.px_out  (px_lv[g+1]),
			.py_out  (py_lv[g+1])
		);
	end

	assign done            = ctl_lv[LAST].valid;
	assign result.point_x  = px_lv[LAST][0];
	assign result.point_y  = py_lv[LAST][0];
	assign result.in_range = ctl_lv[LAST].in_range;

endmodule

// File: rtl/core/bce_checker.sv
`include "assert_macros.svh"

module bce_checker #(
	parameter int LAT = 2 * bce_pkg::MAX_POINTS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input bce_pkg::item_t    item,
	input logic              done,
	input bce_pkg::result_t  result
);

	// every result traces back to exactly one accepted transaction
	`CHK_ALWAYS(a_done_has_cmd, clk, arst_n, !done || $past(start && !busy, LAT))

	`CHK_IMPL(a_cmd_gives_done, clk, arst_n, start && !busy, ##LAT done)

	// sample zero sits on the curve start whatever the point count
	`CHK_IMPL(a_index0_start, clk, arst_n, start && !busy && (item.sample_index == '0), ##LAT (result.point_x == $past(item.ctrl_x0, LAT) && result.point_y == $past(item.ctrl_y0, LAT) && result.in_range))

endmodule

bind bezier_curve_point_eval_top bce_checker #(
	.LAT (2 * MAX_POINTS)
) u_bce_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

// File: tb/sv/tb_bezier_curve_point_eval_top.sv
`timescale 1ns / 1ps

module tb_bezier_curve_point_eval_top;

	localparam int     LATENCY        = 2 * bce_pkg::MAX_POINTS_DEF;
	localparam int     WATCHDOG_LIMIT = 1000;
	localparam int     EXP_DEPTH      = 32;
	localparam longint ONE_Q          = longint'(1) << bce_pkg::FRAC_BITS_DEF;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	bce_pkg::item_t   item;
	logic             done;
	bce_pkg::result_t result;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	// shadow of the register file as the predictor sees it
	logic [bce_pkg::CNT_BITS-1:0]  cfg_point_count = bce_pkg::POINT_COUNT_RST;
	logic [bce_pkg::STEP_BITS-1:0] cfg_t_step      = bce_pkg::T_STEP_RST;

	// ring of expected results, filled on accept and drained on done
	bce_pkg::result_t expected_points [EXP_DEPTH];
	int               exp_put_total  = 0;
	int               exp_get_total  = 0;
	bce_pkg::result_t oldest;
	int               mismatch_count = 0;
	int               idle_cycles    = 0;

	bezier_curve_point_eval_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(string what, longint got, longint want);
		mismatch_count++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic int pending_count();
		return exp_put_total - exp_get_total;
	endfunction

	task automatic enqueue_expected(bce_pkg::result_t r);
		expected_points[exp_put_total[4:0]] = r;
		exp_put_total++;
	endtask

	// whole sum formed exactly, then truncated toward zero
	function automatic longint lerp_q16(longint a, longint b, longint tf);
		return (a * ONE_Q + (b - a) * tf) / ONE_Q;
	endfunction

	function automatic bce_pkg::result_t eval_curve_point(bce_pkg::item_t it);
		longint           px[bce_pkg::NUM_CTRL];
		longint           py[bce_pkg::NUM_CTRL];
		longint           t;
		longint           tf;
		int               n;
		bce_pkg::result_t r;
		px[0] = it.ctrl_x0;
		py[0] = it.ctrl_y0;
		px[1] = it.ctrl_x1;
		py[1] = it.ctrl_y1;
		px[2] = it.ctrl_x2;
		py[2] = it.ctrl_y2;
		px[3] = it.ctrl_x3;
		py[3] = it.ctrl_y3;
		px[4] = it.ctrl_x4;
		py[4] = it.ctrl_y4;
		t = longint'(it.sample_index) * longint'(cfg_t_step);
		r.in_range = (t < ONE_Q);
		tf = r.in_range ? t : ONE_Q;
		n = int'(cfg_point_count);
		if (n > bce_pkg::MAX_POINTS_DEF) n = bce_pkg::MAX_POINTS_DEF;
		if (n > bce_pkg::NUM_CTRL) n = bce_pkg::NUM_CTRL;
		if (n < 1) n = 1;
		for (int lvl = n; lvl > 1; lvl--) begin
			for (int j = 0; j < lvl - 1; j++) begin
				px[j] = lerp_q16(px[j], px[j + 1], tf);
				py[j] = lerp_q16(py[j], py[j + 1], tf);
			end
		end
		r.point_x = px[0][bce_pkg::COORD_BITS-1:0];
		r.point_y = py[0][bce_pkg::COORD_BITS-1:0];
		return r;
	endfunction

	function automatic int pick_gap(bit no_gaps);
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bce_pkg::coord_t random_coord();
		case ($urandom_range(0, 9))
			0:       return bce_pkg::coord_t'(16'h8000);
			1:       return bce_pkg::coord_t'(16'h7FFF);
			2:       return bce_pkg::coord_t'(int'($urandom_range(0, 200)) - 100);
			default: return bce_pkg::coord_t'($urandom);
		endcase
	endfunction

	// mostly samples on the curve, some right past its end, some anywhere
	function automatic logic [bce_pkg::INDEX_BITS-1:0] random_index();
		int max_in;
		int r;
		if (cfg_t_step == 0) return bce_pkg::INDEX_BITS'($urandom);
		max_in = 65535 / cfg_t_step;
		r = $urandom_range(0, 99);
		if (r < 75) return bce_pkg::INDEX_BITS'($urandom_range(0, max_in));
		if (r < 85 && max_in < 65535) return bce_pkg::INDEX_BITS'(max_in + 1);
		return bce_pkg::INDEX_BITS'($urandom);
	endfunction

	function automatic bce_pkg::item_t random_curve_item();
		bce_pkg::item_t it;
		it.ctrl_x0      = random_coord();
		it.ctrl_y0      = random_coord();
		it.ctrl_x1      = random_coord();
		it.ctrl_y1      = random_coord();
		it.ctrl_x2      = random_coord();
		it.ctrl_y2      = random_coord();
		it.ctrl_x3      = random_coord();
		it.ctrl_y3      = random_coord();
		it.ctrl_x4      = random_coord();
		it.ctrl_y4      = random_coord();
		it.sample_index = random_index();
		return it;
	endfunction

	// control points swinging between the coordinate extremes
	function automatic bce_pkg::item_t zigzag_item(logic [bce_pkg::INDEX_BITS-1:0] idx, bit flip);
		bce_pkg::item_t  it;
		bce_pkg::coord_t hi;
		bce_pkg::coord_t lo;
		hi = flip ? bce_pkg::coord_t'(16'h8000) : bce_pkg::coord_t'(16'h7FFF);
		lo = ~hi;
		it.ctrl_x0      = hi;
		it.ctrl_y0      = lo;
		it.ctrl_x1      = lo;
		it.ctrl_y1      = hi;
		it.ctrl_x2      = hi;
		it.ctrl_y2      = lo;
		it.ctrl_x3      = lo;
		it.ctrl_y3      = hi;
		it.ctrl_x4      = hi;
		it.ctrl_y4      = lo;
		it.sample_index = idx;
		return it;
	endfunction

	// start stays high across back-to-back transactions
	task automatic send_item(bce_pkg::item_t it, int gap);
		@(negedge clk);
		start = 1'b1;
		item  = it;
		do @(posedge clk); while (busy);
		enqueue_expected(eval_curve_point(it));
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		start = 1'b0;
		while (pending_count() != 0) @(posedge clk);
	endtask

	task automatic write_reg(bce_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] mask;
		quiesce();
		mask = (idx == bce_pkg::REG_POINT_COUNT) ? (32'd1 << bce_pkg::CNT_BITS) - 32'd1
			: (32'd1 << bce_pkg::STEP_BITS) - 32'd1;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == bce_pkg::REG_POINT_COUNT) begin
			cfg_point_count = value[bce_pkg::CNT_BITS-1:0];
		end else begin
			cfg_t_step = value[bce_pkg::STEP_BITS-1:0];
		end
		// read it straight back
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask))
			flag_mismatch("register readback", prdata & mask, value & mask);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// reset values give 133 as the last index on the curve
	task automatic test_reset_defaults();
		send_item('0, 0);
		send_item(zigzag_item(16'd0, 1'b0), 1);
		send_item(zigzag_item(16'd133, 1'b1), 0);
		send_item(zigzag_item(16'd134, 1'b0), 2);
		send_item(random_curve_item(), 0);
		send_item(zigzag_item(16'hFFFF, 1'b1), 0);
	endtask

	// covers no reduction at 0 and 1 and saturation above five
	task automatic test_point_counts();
		for (int pc = 0; pc < 8; pc++) begin
			write_reg(bce_pkg::REG_POINT_COUNT, 32'(pc));
			send_item(random_curve_item(), pick_gap(1'b0));
		end
	endtask

	task automatic test_step_extremes();
		logic [bce_pkg::STEP_BITS-1:0]  steps[3]   = '{16'd0, 16'd1, 16'hFFFF};
		logic [bce_pkg::INDEX_BITS-1:0] indices[3] = '{16'd0, 16'd1, 16'hFFFF};
		bce_pkg::item_t                 it;
		write_reg(bce_pkg::REG_POINT_COUNT, 32'd3);
		for (int s = 0; s < 3; s++) begin
			write_reg(bce_pkg::REG_T_STEP, 32'(steps[s]));
			for (int i = 0; i < 3; i++) begin
				it = random_curve_item();
				it.sample_index = indices[i];
				send_item(it, pick_gap(1'b0));
			end
		end
	endtask

	task automatic test_random_traffic();
		logic [bce_pkg::CNT_BITS-1:0]  pc;
		logic [bce_pkg::STEP_BITS-1:0] step;
		for (int phase = 0; phase < 12; phase++) begin
			case (phase)
				0: begin pc = 3'd2; step = 16'd1; end
				1: begin pc = 3'd5; step = 16'hFFFF; end
				2: begin pc = 3'd3; step = bce_pkg::T_STEP_RST; end
				3: begin pc = 3'd7; step = bce_pkg::STEP_BITS'($urandom_range(1, 65535)); end
				4: begin pc = 3'd4; step = '0; end
				default: begin
					pc = ($urandom_range(0, 9) < 8) ? bce_pkg::CNT_BITS'($urandom_range(2, 5))
						: bce_pkg::CNT_BITS'($urandom_range(0, 7));
					case ($urandom_range(0, 2))
						0:       step = bce_pkg::STEP_BITS'($urandom_range(1, 4096));
						1:       step = bce_pkg::T_STEP_RST;
						default: step = bce_pkg::STEP_BITS'($urandom_range(1, 65535));
					endcase
				end
			endcase
			write_reg(bce_pkg::REG_POINT_COUNT, 32'(pc));
			write_reg(bce_pkg::REG_T_STEP, 32'(step));
			for (int k = 0; k < 75; k++) begin
				// let the pipeline run dry once mid-phase
				if (phase == 5 && k == 37) quiesce();
				send_item(random_curve_item(), pick_gap(phase % 3 == 1));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_count() == 0) begin
				flag_mismatch("result with nothing outstanding", result.point_x, 0);
			end else begin
				oldest = expected_points[exp_get_total[4:0]];
				exp_get_total++;
				if (result.point_x !== oldest.point_x)
					flag_mismatch("point_x", result.point_x, oldest.point_x);
				if (result.point_y !== oldest.point_y)
					flag_mismatch("point_y", result.point_y, oldest.point_y);
				if (result.in_range !== oldest.in_range)
					flag_mismatch("in_range", result.in_range, oldest.in_range);
			end
		end
		if ((start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_point_counts();
		test_step_extremes();
		test_random_traffic();

		quiesce();
		repeat (LATENCY + 5) @(posedge clk);
		if (mismatch_count == 0 && pending_count() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bce_pkg.sv
rtl/core/bce_tparam.sv
rtl/core/bce_level.sv
rtl/core/bezier_curve_point_eval_top.sv
rtl/core/bce_checker.sv
tb/sv/tb_bezier_curve_point_eval_top.sv
